### hdl/tcsn_pkg.sv
// ----------------------------------------------------------------------------
// Text case and space normalizer package
// Shared constants, types and character helpers for the normalizer core.
// ----------------------------------------------------------------------------
package tcsn_pkg;

   // Longest whitespace run that the run buffer keeps.
   localparam int MAX_RUN = 32;
   localparam int CNT_W   = $clog2(MAX_RUN + 1);
   localparam int IDX_W   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   localparam logic [CNT_W-1:0] RUN_FULL = CNT_W'(MAX_RUN);

   // Configuration port layout.
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_MODE = 1'b0;

   // Mode register codes.
   localparam logic [3:0] MODE_LOWER      = 4'd0;
   localparam logic [3:0] MODE_UPPER      = 4'd1;
   localparam logic [3:0] MODE_PROPER     = 4'd2;
   localparam logic [3:0] MODE_INVERT     = 4'd3;
   localparam logic [3:0] MODE_ALTERNATE  = 4'd4;
   localparam logic [3:0] MODE_SNAKE_LOW  = 4'd5;
   localparam logic [3:0] MODE_SNAKE_UP   = 4'd6;
   localparam logic [3:0] MODE_KEBAB_LOW  = 4'd7;
   localparam logic [3:0] MODE_KEBAB_UP   = 4'd8;
   localparam logic [3:0] MODE_CAMEL      = 4'd9;
   localparam logic [3:0] MODE_PASCAL     = 4'd10;
   localparam logic [3:0] MODE_TRIM_START = 4'd11;
   localparam logic [3:0] MODE_TRIM_END   = 4'd12;
   localparam logic [3:0] MODE_TRIM_BOTH  = 4'd13;
   localparam logic [3:0] MODE_TRIM_INNER = 4'd14;

   // Character constants.
   localparam logic [7:0] CHAR_SPACE      = 8'd32;
   localparam logic [7:0] CHAR_TAB        = 8'd9;
   localparam logic [7:0] CHAR_VT         = 8'd11;
   localparam logic [7:0] CHAR_FF         = 8'd12;
   localparam logic [7:0] CHAR_CR         = 8'd13;
   localparam logic [7:0] CHAR_LF         = 8'd10;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DASH       = 8'h2D;
   localparam logic [7:0] CASE_DELTA      = 8'd32;

   // Whitespace codes held in the run buffer.
   localparam logic [2:0] WS_SPACE = 3'd0;
   localparam logic [2:0] WS_TAB   = 3'd1;
   localparam logic [2:0] WS_VT    = 3'd2;
   localparam logic [2:0] WS_FF    = 3'd3;
   localparam logic [2:0] WS_CR    = 3'd4;
   localparam logic [2:0] WS_LF    = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND,
      ST_TAIL
   } state_type;

   // What one accepted byte turns into.
   typedef enum logic [2:0] {
      PLAN_NONE,
      PLAN_ONE,
      PLAN_MARK,
      PLAN_SEP_CHAR,
      PLAN_HELD_CHAR,
      PLAN_HELD_ONLY
   } plan_type;

   // Source of the word loaded into the output register.
   typedef enum logic [1:0] {
      SRC_FIRST,
      SRC_HELD,
      SRC_TAIL
   } src_type;

   typedef struct packed {
      logic     step;
      logic     load;
      src_type  src;
      logic     rd_next;
   } cmd_type;

   typedef struct packed {
      logic     item_ready;
      logic     out_free;
      plan_type plan;
      logic     rd_last;
      logic     has_tail;
   } status_type;

   function automatic logic is_low(input logic [7:0] c);
      return (c >= 8'd97) && (c <= 8'd122);
   endfunction

   function automatic logic is_up(input logic [7:0] c);
      return (c >= 8'd65) && (c <= 8'd90);
   endfunction

   function automatic logic [7:0] to_low(input logic [7:0] c);
      return is_up(c) ? c + CASE_DELTA : c;
   endfunction

   function automatic logic [7:0] to_up(input logic [7:0] c);
      return is_low(c) ? c - CASE_DELTA : c;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) ||
             (c == CHAR_FF) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic [2:0] ws_code(input logic [7:0] c);
      logic [2:0] code;
      case (c)
         CHAR_TAB: code = WS_TAB;
         CHAR_VT:  code = WS_VT;
         CHAR_FF:  code = WS_FF;
         CHAR_CR:  code = WS_CR;
         CHAR_LF:  code = WS_LF;
         default:  code = WS_SPACE;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] ws_char(input logic [2:0] code);
      logic [7:0] c;
      case (code)
         WS_TAB:  c = CHAR_TAB;
         WS_VT:   c = CHAR_VT;
         WS_FF:   c = CHAR_FF;
         WS_CR:   c = CHAR_CR;
         WS_LF:   c = CHAR_LF;
         default: c = CHAR_SPACE;
      endcase
      return c;
   endfunction

endpackage

### hdl/text_case_and_space_normalizer_core.sv
// ----------------------------------------------------------------------------
// Text case and space normalizer core
// Rewrites a stream of ASCII bytes by case mode and normalizes whitespace
// runs between words, with a mode register on an APB-style port.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports        Word
//  req      in         req_t*       tdata[7:0] byte, tlast end of string
//  rsp      out        rsp_t*       tdata[7:0] byte, tuser valid/run end/overflow,
//                                   tlast end of string
//  csr      in/out     csr_p*       mode register at byte address 0
//
// Plain text moves at one word per cycle while rsp_tready stays high. A
// separator word is sent first and the byte follows from the tail state.
// A held run of n whitespace bytes is replayed through the registered read
// of the run buffer, alternating the read and send states for each byte,
// and then the byte that ended the run, if any, is sent.
// Reset is synchronous and clears all control state; the run buffer is not
// cleared. Input and output registers let a byte be taken while a result
// still waits on rsp_tready.
// ----------------------------------------------------------------------------
module text_case_and_space_normalizer_core
   import tcsn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input byte stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] in_char
   input  logic                  req_tlast,   // in_last
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_char
   output logic [2:0]            rsp_tuser,   // [0] out_valid, [1] run_end, [2] run_overflow
   output logic                  rsp_tlast,   // string_end
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [3:0] mode_ff, mode_in;
   logic       mode_wr;
   cmd_type    cmd;
   status_type status;

   // Mode register.
   assign csr_pready = 1'b1;
   assign mode_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_MODE);
   assign mode_in    = mode_wr ? csr_pwdata[3:0] : mode_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_MODE) ? {28'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LOWER;
      end else begin
         mode_ff <= mode_in;
      end
   end

   tcsn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tcsn_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

`ifndef NO_ASSERTIONS
   // The output register is never overwritten while its word is unsent.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("output word loaded while the previous one is pending");

   // The run replay never steps past its last held byte.
   a_replay_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_next |-> !status.rd_last)
      else $error("run replay advanced past the end of the held run");

   // A bare marker carries a zero byte and closes the byte's results.
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 8'd0) && rsp_tuser[1])
      else $error("bare marker with a nonzero byte or without run end");

   // End of string only comes on the last word of a byte.
   a_string_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[1])
      else $error("string end flagged on a word that is not the last of its byte");
`endif

endmodule

### hdl/tcsn_datapath.sv
// ----------------------------------------------------------------------------
// Normalizer datapath
// Input and output registers, per-string state, the whitespace run buffer
// and the byte rewrite logic. Sequenced by the controller.
// ----------------------------------------------------------------------------
module tcsn_datapath
   import tcsn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  mode,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  cmd_type     cmd,
   output status_type  status
);

   // Input register.
   logic             in_full_ff, in_full_in;
   logic [7:0]       in_char_ff;
   logic             in_last_ff;
   logic             req_accept;

   // Per-string state.
   logic             seen_ff, seen_in;
   logic             prev_ws_ff, prev_ws_in;
   logic             parity_ff, parity_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] held_count_ff, held_count_in;

   // Run buffer and its read side.
   logic [2:0]       held_mem [MAX_RUN];
   logic [2:0]       rd_q_ff;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] run_len_ff, run_len_in;

   // Saved facts of the byte being resolved.
   logic [7:0]       tail_ff, tail_in;
   logic             has_tail_ff, has_tail_in;
   logic             step_last_ff, step_last_in;
   logic             step_over_ff, step_over_in;

   // Output register.
   logic             out_vld_ff, out_vld_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_run_end_ff, out_run_end_in;
   logic             out_str_end_ff, out_str_end_in;
   logic             out_over_ff, out_over_in;

   // Decode of the waiting byte.
   logic             in_ws;
   logic [2:0]       in_code;
   logic             held_nz;
   logic             hold_mode;
   logic             hold;
   logic             lead_drop;
   logic             wr_en;
   logic             over_step;
   logic [CNT_W-1:0] count_after;
   logic             word_start;
   logic [7:0]       xform;
   logic [7:0]       first_char;
   plan_type         plan;
   logic             held_run_end;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !in_full_ff || cmd.step;

   // Classify the byte and plan the words it produces.
   always_comb begin
      in_ws       = is_ws(in_char_ff);
      in_code     = ws_code(in_char_ff);
      held_nz     = (held_count_ff != '0);
      hold_mode   = ((mode >= MODE_SNAKE_LOW) && (mode <= MODE_PASCAL)) ||
                    (mode == MODE_TRIM_END) || (mode == MODE_TRIM_BOTH) ||
                    (mode == MODE_TRIM_INNER);
      hold        = in_ws && (held_nz || (mode == MODE_TRIM_END) || (seen_ff && hold_mode));
      lead_drop   = in_ws && !hold && !seen_ff &&
                    ((mode == MODE_TRIM_START) || (mode == MODE_TRIM_BOTH));
      wr_en       = hold && (held_count_ff < RUN_FULL);
      over_step   = ovf_ff || (hold && !wr_en);
      count_after = wr_en ? held_count_ff + CNT_W'(1) : held_count_ff;
      word_start  = (held_nz && ((mode == MODE_CAMEL) || (mode == MODE_PASCAL))) ||
                    ((mode == MODE_PASCAL) && !seen_ff);

      // Case rewrite of a non-space byte.
      case (mode)
         MODE_LOWER, MODE_SNAKE_LOW, MODE_KEBAB_LOW: xform = to_low(in_char_ff);
         MODE_UPPER, MODE_SNAKE_UP, MODE_KEBAB_UP:   xform = to_up(in_char_ff);
         MODE_PROPER:
            xform = (prev_ws_ff || !seen_ff) ? to_up(in_char_ff) : to_low(in_char_ff);
         MODE_INVERT:
            xform = is_up(in_char_ff) ? in_char_ff + CASE_DELTA :
                    (is_low(in_char_ff) ? in_char_ff - CASE_DELTA : in_char_ff);
         MODE_ALTERNATE:
            xform = parity_ff ? to_up(in_char_ff) : to_low(in_char_ff);
         MODE_CAMEL, MODE_PASCAL:
            xform = word_start ? to_up(in_char_ff) : to_low(in_char_ff);
         default: xform = in_char_ff;
      endcase

      first_char = xform;
      plan       = PLAN_ONE;
      if (in_ws) begin
         first_char = in_char_ff;
         if (hold) begin
            if (!in_last_ff) begin
               plan = PLAN_NONE;
            end else if ((mode != MODE_TRIM_END) && (mode != MODE_TRIM_BOTH)) begin
               plan = PLAN_HELD_ONLY;
            end else begin
               plan = PLAN_MARK;
            end
         end else if (lead_drop) begin
            plan = in_last_ff ? PLAN_MARK : PLAN_NONE;
         end
      end else if (held_nz) begin
         if ((mode >= MODE_SNAKE_LOW) && (mode <= MODE_KEBAB_UP)) begin
            plan       = PLAN_SEP_CHAR;
            first_char = (mode <= MODE_SNAKE_UP) ? CHAR_UNDERSCORE : CHAR_DASH;
         end else if ((mode != MODE_CAMEL) && (mode != MODE_PASCAL) &&
                      (mode != MODE_TRIM_INNER)) begin
            plan = PLAN_HELD_CHAR;
         end
      end
   end

   assign held_run_end = status.rd_last && !has_tail_ff;

   assign status.item_ready = in_full_ff;
   assign status.out_free   = !out_vld_ff || rsp_tready;
   assign status.plan       = plan;
   assign status.rd_last    = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == run_len_ff;
   assign status.has_tail   = has_tail_ff;

   // Next values of the control state.
   always_comb begin
      in_full_in    = in_full_ff;
      seen_in       = seen_ff;
      prev_ws_in    = prev_ws_ff;
      parity_in     = parity_ff;
      ovf_in        = ovf_ff;
      held_count_in = held_count_ff;
      rd_idx_in     = rd_idx_ff;
      run_len_in    = run_len_ff;
      tail_in       = tail_ff;
      has_tail_in   = has_tail_ff;
      step_last_in  = step_last_ff;
      step_over_in  = step_over_ff;

      if (req_accept) begin
         in_full_in = 1'b1;
      end else if (cmd.step) begin
         in_full_in = 1'b0;
      end

      if (cmd.step) begin
         tail_in      = xform;
         has_tail_in  = (plan == PLAN_HELD_CHAR);
         run_len_in   = (plan == PLAN_HELD_ONLY) ? count_after : held_count_ff;
         step_last_in = in_last_ff;
         step_over_in = over_step;
         rd_idx_in    = '0;
         parity_in    = !parity_ff;
         prev_ws_in   = in_ws;
         if (in_ws) begin
            held_count_in = count_after;
            ovf_in        = over_step;
         end else begin
            seen_in       = 1'b1;
            held_count_in = '0;
            ovf_in        = 1'b0;
         end
         // A string's end clears the per-string state for the next one.
         if (in_last_ff) begin
            seen_in       = 1'b0;
            prev_ws_in    = 1'b0;
            parity_in     = 1'b0;
            ovf_in        = 1'b0;
            held_count_in = '0;
         end
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
   end

   // Next values of the output register.
   always_comb begin
      out_vld_in     = out_vld_ff;
      out_char_in    = out_char_ff;
      out_valid_in   = out_valid_ff;
      out_run_end_in = out_run_end_ff;
      out_str_end_in = out_str_end_ff;
      out_over_in    = out_over_ff;
      if (cmd.load) begin
         out_vld_in = 1'b1;
         case (cmd.src)
            SRC_FIRST: begin
               out_valid_in   = (plan != PLAN_MARK);
               out_char_in    = (plan == PLAN_MARK) ? 8'd0 : first_char;
               out_run_end_in = (plan != PLAN_SEP_CHAR);
               out_str_end_in = in_last_ff && (plan != PLAN_SEP_CHAR);
               out_over_in    = over_step;
            end
            SRC_HELD: begin
               out_valid_in   = 1'b1;
               out_char_in    = ws_char(rd_q_ff);
               out_run_end_in = held_run_end;
               out_str_end_in = held_run_end && step_last_ff;
               out_over_in    = step_over_ff;
            end
            SRC_TAIL: begin
               out_valid_in   = 1'b1;
               out_char_in    = tail_ff;
               out_run_end_in = 1'b1;
               out_str_end_in = step_last_ff;
               out_over_in    = step_over_ff;
            end
            default: begin
               out_valid_in   = 1'b0;
               out_char_in    = 8'd0;
               out_run_end_in = 1'b1;
               out_str_end_in = 1'b0;
               out_over_in    = 1'b0;
            end
         endcase
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff    <= 1'b0;
         seen_ff       <= 1'b0;
         prev_ws_ff    <= 1'b0;
         parity_ff     <= 1'b0;
         ovf_ff        <= 1'b0;
         held_count_ff <= '0;
         rd_idx_ff     <= '0;
         run_len_ff    <= '0;
         has_tail_ff   <= 1'b0;
         step_last_ff  <= 1'b0;
         step_over_ff  <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         in_full_ff    <= in_full_in;
         seen_ff       <= seen_in;
         prev_ws_ff    <= prev_ws_in;
         parity_ff     <= parity_in;
         ovf_ff        <= ovf_in;
         held_count_ff <= held_count_in;
         rd_idx_ff     <= rd_idx_in;
         run_len_ff    <= run_len_in;
         has_tail_ff   <= has_tail_in;
         step_last_ff  <= step_last_in;
         step_over_ff  <= step_over_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      tail_ff        <= tail_in;
      out_char_ff    <= out_char_in;
      out_valid_ff   <= out_valid_in;
      out_run_end_ff <= out_run_end_in;
      out_str_end_ff <= out_str_end_in;
      out_over_ff    <= out_over_in;
   end

   // Run buffer: one write port at the fill position, one registered read.
   always_ff @(posedge clock) begin
      if (cmd.step && wr_en) begin
         held_mem[held_count_ff[IDX_W-1:0]] <= in_code;
      end
      rd_q_ff <= held_mem[rd_idx_ff];
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = {out_over_ff, out_run_end_ff, out_valid_ff};
   assign rsp_tlast  = out_str_end_ff;

endmodule

### hdl/tcsn_ctrl.sv
// ----------------------------------------------------------------------------
// Normalizer controller
// Takes one byte at a time and sequences the words it produces: a single
// word, a separator and a byte, or a replay of the held run, with or without the byte.
// ----------------------------------------------------------------------------
module tcsn_ctrl
   import tcsn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd.step    = 1'b0;
      cmd.load    = 1'b0;
      cmd.src     = SRC_FIRST;
      cmd.rd_next = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (status.item_ready && status.out_free) begin
               cmd.step = 1'b1;
               case (status.plan)
                  PLAN_ONE, PLAN_MARK: begin
                     cmd.load = 1'b1;
                  end
                  PLAN_SEP_CHAR: begin
                     cmd.load = 1'b1;
                     state_in = ST_TAIL;
                  end
                  PLAN_HELD_CHAR, PLAN_HELD_ONLY: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_HELD;
               if (status.rd_last) begin
                  state_in = status.has_tail ? ST_TAIL : ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_TAIL;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
